// File: rtl/rpoh_pkg.sv
// ----------------------------------------------------------------------------
// RSSI packet outcome histogram: shared definitions
// Sizes, function and operation codes, and the command type that travels
// from the classifier through the queue to the counter bank.
// ----------------------------------------------------------------------------
package rpoh_pkg;

    localparam int RSSI_BINS       = 7;
    localparam int BURST_BINS      = 10;
    localparam int COUNT_W         = 32;
    localparam int EDGE_COUNT      = RSSI_BINS - 1;
    localparam int EDGE_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int RBIN_W          = $clog2(EDGE_COUNT + 1);
    localparam int BIN_COUNT       = 3 * RSSI_BINS + BURST_BINS;
    localparam int ADDR_W          = $clog2(BIN_COUNT);
    localparam int BURST_BASE_ADDR = 3 * RSSI_BINS;
    localparam int READ_BURST_BASE = 24;
    localparam int READ_BURST_TOT  = READ_BURST_BASE + BURST_BINS;
    localparam int CATS            = 4;
    localparam int TOT_W           = $clog2(CATS);
    localparam int BIN_OUT_W       = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic signed [EDGE_W-1:0] EDGE_RESET [EDGE_COUNT] = '{
        -8'sd80, -8'sd70, -8'sd60, -8'sd50, -8'sd40, -8'sd30
    };

    localparam logic [2:0] FUNC_GOOD    = 3'd0;
    localparam logic [2:0] FUNC_CRC     = 3'd1;
    localparam logic [2:0] FUNC_TIMEOUT = 3'd2;
    localparam logic [2:0] FUNC_BURST   = 3'd3;
    localparam logic [2:0] FUNC_READ    = 3'd4;
    localparam logic [2:0] FUNC_CLEAR   = 3'd5;

    localparam logic [TOT_W-1:0] TOT_BURST = TOT_W'(3);

    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_UPDATE   = 3'd1;
    localparam logic [2:0] OP_READ_BIN = 3'd2;
    localparam logic [2:0] OP_READ_TOT = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    typedef struct packed {
        logic [2:0]           op;
        logic [ADDR_W-1:0]    addr;
        logic [TOT_W-1:0]     tot;
        logic [BIN_OUT_W-1:0] bin;
        logic                 ierr;
        logic                 ign;
    } t_cmd;

endpackage

// File: rtl/rpoh_front.sv
// ----------------------------------------------------------------------------
// RSSI packet outcome histogram: front end
// Holds the bin edge registers and turns each accepted item into a command
// for the counter bank.
// ----------------------------------------------------------------------------
module rpoh_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rpoh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rpoh_pkg::EDGE_W-1:0]          i_cfg_data,
    input  logic [2:0]                           i_func,
    input  logic signed [7:0]                    i_rssi,
    input  logic [7:0]                           i_burst_length,
    input  logic [5:0]                           i_counter_index,
    output rpoh_pkg::t_cmd                       o_cmd
);

    logic signed [rpoh_pkg::EDGE_W-1:0] r_edge [rpoh_pkg::EDGE_COUNT];
    logic [rpoh_pkg::EDGE_COUNT-1:0]    ge;
    logic [rpoh_pkg::RBIN_W-1:0]        rbin;
    logic [7:0]                         burst_bin;
    logic [1:0]                         cat;
    logic [2:0]                         sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rpoh_pkg::EDGE_COUNT; k++) begin
                r_edge[k] <= rpoh_pkg::EDGE_RESET[k];
            end
        end else if (i_cfg_we && (i_cfg_index < rpoh_pkg::CFG_IDX_W'(rpoh_pkg::EDGE_COUNT))) begin
            r_edge[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int k = 0; k < rpoh_pkg::EDGE_COUNT; k++) begin
            ge[k] = (i_rssi >= r_edge[k]);
        end
        rbin = rpoh_pkg::RBIN_W'($countones(ge));
        burst_bin = (i_burst_length >= 8'(rpoh_pkg::BURST_BINS))
                  ? 8'(rpoh_pkg::BURST_BINS - 1) : i_burst_length - 8'd1;
        cat = i_counter_index[4:3];
        sub = i_counter_index[2:0];
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.op = rpoh_pkg::OP_NONE;
        unique case (i_func)
            rpoh_pkg::FUNC_GOOD, rpoh_pkg::FUNC_CRC, rpoh_pkg::FUNC_TIMEOUT: begin
                o_cmd.op   = rpoh_pkg::OP_UPDATE;
                o_cmd.addr = rpoh_pkg::ADDR_W'(i_func[1:0]) * rpoh_pkg::ADDR_W'(rpoh_pkg::RSSI_BINS)
                           + rpoh_pkg::ADDR_W'(rbin);
                o_cmd.tot  = rpoh_pkg::TOT_W'(i_func[1:0]);
                o_cmd.bin  = rpoh_pkg::BIN_OUT_W'(rbin);
            end
            rpoh_pkg::FUNC_BURST: begin
                if (i_burst_length == 8'd0) begin
                    o_cmd.ign = 1'b1;
                end else begin
                    o_cmd.op   = rpoh_pkg::OP_UPDATE;
                    o_cmd.addr = rpoh_pkg::ADDR_W'(rpoh_pkg::BURST_BASE_ADDR)
                               + rpoh_pkg::ADDR_W'(burst_bin);
                    o_cmd.tot  = rpoh_pkg::TOT_BURST;
                    o_cmd.bin  = rpoh_pkg::BIN_OUT_W'(burst_bin);
                end
            end
            rpoh_pkg::FUNC_READ: begin
                if (i_counter_index < 6'(rpoh_pkg::READ_BURST_BASE)) begin
                    if (sub < 3'(rpoh_pkg::RSSI_BINS)) begin
                        o_cmd.op   = rpoh_pkg::OP_READ_BIN;
                        o_cmd.addr = rpoh_pkg::ADDR_W'(cat) * rpoh_pkg::ADDR_W'(rpoh_pkg::RSSI_BINS)
                                   + rpoh_pkg::ADDR_W'(sub);
                    end else begin
                        o_cmd.op  = rpoh_pkg::OP_READ_TOT;
                        o_cmd.tot = rpoh_pkg::TOT_W'(cat);
                    end
                end else if (i_counter_index < 6'(rpoh_pkg::READ_BURST_TOT)) begin
                    o_cmd.op   = rpoh_pkg::OP_READ_BIN;
                    o_cmd.addr = rpoh_pkg::ADDR_W'(rpoh_pkg::BURST_BASE_ADDR)
                               + rpoh_pkg::ADDR_W'(i_counter_index
                                                   - 6'(rpoh_pkg::READ_BURST_BASE));
                end else if (i_counter_index == 6'(rpoh_pkg::READ_BURST_TOT)) begin
                    o_cmd.op  = rpoh_pkg::OP_READ_TOT;
                    o_cmd.tot = rpoh_pkg::TOT_BURST;
                end else begin
                    o_cmd.ierr = 1'b1;
                end
            end
            rpoh_pkg::FUNC_CLEAR: begin
                o_cmd.op = rpoh_pkg::OP_CLEAR;
            end
            default: begin
                o_cmd.op = rpoh_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// File: rtl/rpoh_queue.sv
// ----------------------------------------------------------------------------
// RSSI packet outcome histogram: command queue
// A short first-in first-out buffer between classifier and counter bank.
// The head is handed on whenever the queue holds a command.
// ----------------------------------------------------------------------------
module rpoh_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rpoh_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_head_valid,
    output rpoh_pkg::t_cmd o_head
);

    localparam int PTR_W = $clog2(rpoh_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rpoh_pkg::QUEUE_DEPTH + 1);

    rpoh_pkg::t_cmd   r_mem [rpoh_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             push_ok;
    logic             pop;

    assign o_full       = (r_cnt == CNT_W'(rpoh_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign push_ok      = i_push && !o_full;
    assign pop          = o_head_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(rpoh_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(rpoh_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/rpoh_back.sv
// ----------------------------------------------------------------------------
// RSSI packet outcome histogram: counter bank
// Holds the bin counters and the category totals, carries out one command
// per cycle and registers its result.
// ----------------------------------------------------------------------------
module rpoh_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  rpoh_pkg::t_cmd                    i_cmd,
    output logic                              o_valid,
    output logic [rpoh_pkg::BIN_OUT_W-1:0]    o_bin_index,
    output logic [rpoh_pkg::COUNT_W-1:0]      o_count,
    output logic                              o_index_error,
    output logic                              o_was_ignored
);

    logic [rpoh_pkg::COUNT_W-1:0] r_bins   [rpoh_pkg::BIN_COUNT];
    logic [rpoh_pkg::COUNT_W-1:0] r_totals [rpoh_pkg::CATS];
    logic                         r_valid;
    logic [rpoh_pkg::BIN_OUT_W-1:0] r_bin;
    logic [rpoh_pkg::COUNT_W-1:0] r_count;
    logic                         r_ierr;
    logic                         r_ign;
    logic [rpoh_pkg::COUNT_W-1:0] bin_now;
    logic [rpoh_pkg::COUNT_W-1:0] tot_now;
    logic [rpoh_pkg::COUNT_W-1:0] n_bin;
    logic [rpoh_pkg::COUNT_W-1:0] n_tot;
    logic [rpoh_pkg::COUNT_W-1:0] n_count;

    always_comb begin
        bin_now = r_bins[i_cmd.addr];
        tot_now = r_totals[i_cmd.tot];
        n_bin   = bin_now + 1'b1;
        n_tot   = tot_now + 1'b1;
        unique case (i_cmd.op)
            rpoh_pkg::OP_UPDATE:   n_count = n_bin;
            rpoh_pkg::OP_READ_BIN: n_count = bin_now;
            rpoh_pkg::OP_READ_TOT: n_count = tot_now;
            default:               n_count = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rpoh_pkg::BIN_COUNT; k++) begin
                r_bins[k] <= '0;
            end
            for (int k = 0; k < rpoh_pkg::CATS; k++) begin
                r_totals[k] <= '0;
            end
        end else if (i_cmd_valid && (i_cmd.op == rpoh_pkg::OP_CLEAR)) begin
            for (int k = 0; k < rpoh_pkg::BIN_COUNT; k++) begin
                r_bins[k] <= '0;
            end
            for (int k = 0; k < rpoh_pkg::CATS; k++) begin
                r_totals[k] <= '0;
            end
        end else if (i_cmd_valid && (i_cmd.op == rpoh_pkg::OP_UPDATE)) begin
            r_bins[i_cmd.addr]  <= n_bin;
            r_totals[i_cmd.tot] <= n_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_valid) begin
            r_bin   <= i_cmd.bin;
            r_count <= n_count;
            r_ierr  <= i_cmd.ierr;
            r_ign   <= i_cmd.ign;
        end
    end

    assign o_valid       = r_valid;
    assign o_bin_index   = r_bin;
    assign o_count       = r_count;
    assign o_index_error = r_ierr;
    assign o_was_ignored = r_ign;

endmodule

// File: rtl/rssi_packet_outcome_histogram_core.sv
// ----------------------------------------------------------------------------
// RSSI packet outcome histogram core
// Packet and error-burst statistics with programmable RSSI bin edges.
//
// An item is accepted at a clock edge where i_start is high and o_busy is
// low. Its function code selects a good, CRC-failed or timed-out packet
// record, an error-burst record, a counter read or a clear of all counters.
// Every item gives exactly one result, shown for one cycle with o_valid high;
// the receiver cannot stall it.
// The classifier writes a command into a two-entry queue at the accepting
// edge, the counter bank takes it at the next edge, and the result is on the
// ports in the cycle after that. The counter bank retires one command per
// cycle, so an item can be accepted every cycle and o_busy stays low in
// normal use.
// Reset sets the six bin edges to -80, -70, -60, -50, -40 and -30 dBm and
// clears all counters in the same cycle. Bin edges go in through i_cfg_we,
// i_cfg_index and i_cfg_data; the user writes them only while no item is in
// flight, the block does not enforce it, and an index above five is ignored.
// ----------------------------------------------------------------------------
module rssi_packet_outcome_histogram_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpoh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpoh_pkg::EDGE_W-1:0]    i_cfg_data,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [2:0]                     i_func,
    input  logic signed [7:0]              i_rssi,
    input  logic [7:0]                     i_burst_length,
    input  logic [5:0]                     i_counter_index,
    output logic                           o_valid,
    output logic [3:0]                     o_bin_index,
    output logic [31:0]                    o_count_value,
    output logic                           o_index_error,
    output logic                           o_was_ignored
);

    rpoh_pkg::t_cmd               cmd;
    rpoh_pkg::t_cmd               head;
    logic                         full;
    logic                         head_valid;
    logic [rpoh_pkg::COUNT_W-1:0] count;
    logic [rpoh_pkg::BIN_OUT_W-1:0] bin;

    rpoh_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_rssi          (i_rssi),
        .i_burst_length  (i_burst_length),
        .i_counter_index (i_counter_index),
        .o_cmd           (cmd)
    );

    rpoh_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_start && !full),
        .i_cmd        (cmd),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    rpoh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (head_valid),
        .i_cmd         (head),
        .o_valid       (o_valid),
        .o_bin_index   (bin),
        .o_count       (count),
        .o_index_error (o_index_error),
        .o_was_ignored (o_was_ignored)
    );

    assign o_busy        = full;
    assign o_bin_index   = 4'(bin);
    assign o_count_value = 32'(count);

endmodule

// File: rtl/rpoh_checker.sv
// ----------------------------------------------------------------------------
// RSSI packet outcome histogram: port checker
// Watches the top-level ports for item-to-result timing and result fields
// that cannot occur together.
// ----------------------------------------------------------------------------
module rpoh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_valid,
    input logic [3:0]  o_bin_index,
    input logic [31:0] o_count_value,
    input logic        o_index_error,
    input logic        o_was_ignored
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_valid)
        else $error("An accepted item gave no result two cycles later.");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 2))
        else $error("A result appeared without an accepted item.");

    a_ignored_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_ignored) |->
            (o_bin_index == 4'd0 && o_count_value == 32'd0 && !o_index_error))
        else $error("An ignored burst reported a bin or a count.");

    a_index_error_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_error) |-> (o_count_value == 32'd0 && o_bin_index == 4'd0))
        else $error("A bad read index reported a count.");

endmodule

bind rssi_packet_outcome_histogram_core rpoh_checker u_rpoh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_valid       (o_valid),
    .o_bin_index   (o_bin_index),
    .o_count_value (o_count_value),
    .o_index_error (o_index_error),
    .o_was_ignored (o_was_ignored)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the RSSI packet outcome histogram core
// Drives packet, burst, read, clear and unused commands with random gaps,
// reprograms the six bin edges between phases, and checks every result
// in order against table values or a histogram model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import rpoh_pkg::*;

    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
    localparam bit         TYPED        = 1'b1;
    localparam bit         PREDICTED    = 1'b0;
    localparam int         PHASE_ITEMS  = 88;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_1, REG_EDGE_2, REG_EDGE_3, REG_EDGE_4, REG_EDGE_5, REG_EDGE_6,
        REG_SPARE_A, REG_SPARE_B
    } cfg_reg_t;

    typedef enum int {
        PLAN_ASCEND, PLAN_FLOOR, PLAN_CEIL, PLAN_DESCEND, PLAN_SCATTER, PLAN_DEFAULT
    } edge_plan_t;

    typedef struct packed {
        logic [2:0]        func;
        logic signed [7:0] rssi;
        logic [7:0]        blen;
        logic [5:0]        cidx;
    } item_t;

    typedef struct packed {
        logic [3:0]  bin;
        logic [31:0] count;
        logic        ierr;
        logic        ign;
    } outcome_t;

    typedef struct packed {
        item_t    it;
        logic     typed;
        outcome_t want;
    } row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [EDGE_W-1:0]    i_cfg_data;
    logic                 i_start;
    logic                 o_busy;
    logic [2:0]           i_func;
    logic signed [7:0]    i_rssi;
    logic [7:0]           i_burst_length;
    logic [5:0]           i_counter_index;
    logic                 o_valid;
    logic [3:0]           o_bin_index;
    logic [31:0]          o_count_value;
    logic                 o_index_error;
    logic                 o_was_ignored;

    rssi_packet_outcome_histogram_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_func          (i_func),
        .i_rssi          (i_rssi),
        .i_burst_length  (i_burst_length),
        .i_counter_index (i_counter_index),
        .o_valid         (o_valid),
        .o_bin_index     (o_bin_index),
        .o_count_value   (o_count_value),
        .o_index_error   (o_index_error),
        .o_was_ignored   (o_was_ignored)
    );

    // Histogram state mirrored by the bench.
    logic signed [EDGE_W-1:0] bin_floor [EDGE_COUNT];
    logic signed [EDGE_W-1:0] next_floor [EDGE_COUNT];
    logic [COUNT_W-1:0]       pkt_counts [3][RSSI_BINS];
    logic [COUNT_W-1:0]       burst_counts [BURST_BINS];
    logic [COUNT_W-1:0]       cat_totals [CATS];

    outcome_t results_due [$];
    row_t     directed_rows [$];

    int errors;
    int n_checked;
    int n_records;
    int n_bursts;
    int n_reads;
    int n_clears;
    int n_noops;
    int n_settings;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void clear_counts();
        for (int c = 0; c < 3; c++)
            for (int b = 0; b < RSSI_BINS; b++)
                pkt_counts[c][b] = '0;
        for (int b = 0; b < BURST_BINS; b++)
            burst_counts[b] = '0;
        for (int c = 0; c < CATS; c++)
            cat_totals[c] = '0;
    endfunction

    function automatic outcome_t tally_item(input item_t it);
        outcome_t r;
        int       b;
        int       cat;
        int       sub;
        r = '0;
        case (it.func)
            FUNC_GOOD, FUNC_CRC, FUNC_TIMEOUT: begin
                b = 0;
                for (int i = 0; i < EDGE_COUNT; i++)
                    if ($signed(it.rssi) >= $signed(bin_floor[i]))
                        b++;
                pkt_counts[it.func][b] = pkt_counts[it.func][b] + 1'b1;
                cat_totals[it.func]    = cat_totals[it.func] + 1'b1;
                r.bin   = 4'(b);
                r.count = pkt_counts[it.func][b];
            end
            FUNC_BURST: begin
                if (it.blen == 8'd0) begin
                    r.ign = 1'b1;
                end else begin
                    b = (it.blen >= BURST_BINS) ? BURST_BINS - 1 : int'(it.blen) - 1;
                    burst_counts[b]       = burst_counts[b] + 1'b1;
                    cat_totals[TOT_BURST] = cat_totals[TOT_BURST] + 1'b1;
                    r.bin   = 4'(b);
                    r.count = burst_counts[b];
                end
            end
            FUNC_READ: begin
                if (it.cidx < READ_BURST_BASE) begin
                    cat = int'(it.cidx) >> 3;
                    sub = int'(it.cidx[2:0]);
                    r.count = (sub < RSSI_BINS) ? pkt_counts[cat][sub] : cat_totals[cat];
                end else if (it.cidx < READ_BURST_TOT) begin
                    r.count = burst_counts[int'(it.cidx) - READ_BURST_BASE];
                end else if (it.cidx == READ_BURST_TOT) begin
                    r.count = cat_totals[TOT_BURST];
                end else begin
                    r.ierr = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                clear_counts();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic row_t mk_row(input logic [2:0] func, input int rssi, input int blen,
                                    input int cidx, input bit typed, input int bin,
                                    input int unsigned cnt, input bit ierr, input bit ign);
        row_t r;
        r.it.func    = func;
        r.it.rssi    = 8'(rssi);
        r.it.blen    = 8'(blen);
        r.it.cidx    = 6'(cidx);
        r.typed      = typed;
        r.want.bin   = 4'(bin);
        r.want.count = cnt;
        r.want.ierr  = ierr;
        r.want.ign   = ign;
        return r;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    sel;
        int    v;
        sel = $urandom_range(0, 99);
        if (sel < 22)      it.func = FUNC_GOOD;
        else if (sel < 34) it.func = FUNC_CRC;
        else if (sel < 46) it.func = FUNC_TIMEOUT;
        else if (sel < 64) it.func = FUNC_BURST;
        else if (sel < 94) it.func = FUNC_READ;
        else if (sel < 96) it.func = FUNC_CLEAR;
        else if (sel < 98) it.func = FUNC_SPARE_6;
        else               it.func = FUNC_SPARE_7;
        if ($urandom_range(0, 1) == 0) begin
            it.rssi = 8'($urandom_range(0, 255));
        end else begin
            v = int'(bin_floor[$urandom_range(0, EDGE_COUNT - 1)]) +
                int'($urandom_range(0, 2)) - 1;
            if (v < -128) v = -128;
            if (v > 127) v = 127;
            it.rssi = 8'(v);
        end
        it.blen = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 12))
                                             : 8'($urandom_range(0, 255));
        it.cidx = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, READ_BURST_TOT))
                                             : 6'($urandom_range(0, 63));
        return it;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void build_floor(input edge_plan_t plan);
        int v;
        v = -128 + int'($urandom_range(0, 60));
        for (int i = 0; i < EDGE_COUNT; i++) begin
            case (plan)
                PLAN_ASCEND:  next_floor[i] = 8'(v);
                PLAN_DESCEND: next_floor[EDGE_COUNT - 1 - i] = 8'(v);
                PLAN_FLOOR:   next_floor[i] = -8'sd128;
                PLAN_CEIL:    next_floor[i] = 8'sd127;
                PLAN_SCATTER: next_floor[i] = 8'($urandom_range(0, 255));
                default:      next_floor[i] = EDGE_RESET[i];
            endcase
            v = v + int'($urandom_range(0, 35));
            if (v > 127) v = 127;
        end
    endfunction

    task automatic program_edges();
        for (int i = 0; i < EDGE_COUNT; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_EDGE_1 + CFG_IDX_W'(i);
            i_cfg_data  <= next_floor[i];
            @(posedge i_clk);
            bin_floor[i] = next_floor[i];
        end
        // Writes above the last edge register must leave the edges alone.
        i_cfg_index <= REG_SPARE_A;
        i_cfg_data  <= EDGE_W'($urandom_range(0, 255));
        @(posedge i_clk);
        i_cfg_index <= REG_SPARE_B;
        i_cfg_data  <= EDGE_W'($urandom_range(0, 255));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_item(input item_t it, input bit typed, input outcome_t want);
        outcome_t model_out;
        i_start         <= 1'b1;
        i_func          <= it.func;
        i_rssi          <= it.rssi;
        i_burst_length  <= it.blen;
        i_counter_index <= it.cidx;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        model_out = tally_item(it);
        results_due.push_back(typed ? want : model_out);
        case (it.func)
            FUNC_GOOD, FUNC_CRC, FUNC_TIMEOUT: n_records++;
            FUNC_BURST: if (it.blen != 8'd0) n_bursts++; else n_noops++;
            FUNC_READ:  n_reads++;
            FUNC_CLEAR: n_clears++;
            default:    n_noops++;
        endcase
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : watch_results
        outcome_t w;
        if (i_rst_n && o_valid) begin
            if (results_due.size() == 0) begin
                flag_error("result arrived with no item outstanding");
            end else begin
                w = results_due.pop_front();
                n_checked++;
                if (o_bin_index !== w.bin)
                    flag_error($sformatf("bin_index got %0d want %0d", o_bin_index, w.bin));
                if (o_count_value !== w.count)
                    flag_error($sformatf("count_value got %0d want %0d",
                                         o_count_value, w.count));
                if (o_index_error !== w.ierr)
                    flag_error($sformatf("index_error got %b want %b", o_index_error, w.ierr));
                if (o_was_ignored !== w.ign)
                    flag_error($sformatf("was_ignored got %b want %b", o_was_ignored, w.ign));
            end
        end
    end

    initial begin
        #2000000;
        $display("rssi_packet_outcome_histogram_core test failed");
        $finish;
    end

    initial begin
        item_t it;
        int    done;
        bit    calm;

        errors     = 0;
        n_checked  = 0;
        n_records  = 0;
        n_bursts   = 0;
        n_reads    = 0;
        n_clears   = 0;
        n_noops    = 0;
        n_settings = 1;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_EDGE_1;
        i_cfg_data      = '0;
        i_start         = 1'b0;
        i_func          = FUNC_GOOD;
        i_rssi          = '0;
        i_burst_length  = '0;
        i_counter_index = '0;

        for (int i = 0; i < EDGE_COUNT; i++)
            bin_floor[i] = EDGE_RESET[i];
        clear_counts();

        // func, rssi, burst length, counter index, typed, bin, count, index error, ignored
        directed_rows.push_back(mk_row(FUNC_READ, 0, 0, 0, TYPED, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_READ, 0, 0, READ_BURST_TOT, TYPED, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_READ, 0, 0, 35, TYPED, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(FUNC_READ, -1, 255, 63, TYPED, 0, 0, 1, 0));
        directed_rows.push_back(mk_row(FUNC_GOOD, -128, 0, 0, TYPED, 0, 1, 0, 0));
        directed_rows.push_back(mk_row(FUNC_GOOD, 127, 0, 0, TYPED, 6, 1, 0, 0));
        directed_rows.push_back(mk_row(FUNC_CRC, -80, 0, 0, TYPED, 1, 1, 0, 0));
        directed_rows.push_back(mk_row(FUNC_CRC, -81, 0, 0, TYPED, 0, 1, 0, 0));
        directed_rows.push_back(mk_row(FUNC_TIMEOUT, -30, 0, 0, TYPED, 6, 1, 0, 0));
        directed_rows.push_back(mk_row(FUNC_TIMEOUT, -31, 0, 0, TYPED, 5, 1, 0, 0));
        directed_rows.push_back(mk_row(FUNC_BURST, 0, 0, 0, TYPED, 0, 0, 0, 1));
        directed_rows.push_back(mk_row(FUNC_BURST, 0, 1, 0, TYPED, 0, 1, 0, 0));
        directed_rows.push_back(mk_row(FUNC_BURST, 0, 9, 0, TYPED, 8, 1, 0, 0));
        directed_rows.push_back(mk_row(FUNC_BURST, 0, 10, 0, TYPED, 9, 1, 0, 0));
        directed_rows.push_back(mk_row(FUNC_BURST, 0, 255, 0, TYPED, 9, 2, 0, 0));
        directed_rows.push_back(mk_row(FUNC_READ, 0, 0, 7, TYPED, 0, 2, 0, 0));
        directed_rows.push_back(mk_row(FUNC_READ, 0, 0, 33, TYPED, 0, 2, 0, 0));
        directed_rows.push_back(mk_row(FUNC_READ, 0, 0, READ_BURST_TOT, TYPED, 0, 4, 0, 0));
        directed_rows.push_back(mk_row(FUNC_READ, 0, 0, 23, TYPED, 0, 2, 0, 0));
        directed_rows.push_back(mk_row(FUNC_SPARE_6, 127, 255, 63, TYPED, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_SPARE_7, -128, 5, 7, TYPED, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_CLEAR, 127, 255, 63, TYPED, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_READ, 0, 0, 7, TYPED, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_GOOD, -55, 0, 0, PREDICTED, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_BURST, 0, 5, 0, PREDICTED, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_READ, 0, 0, 3, PREDICTED, 0, 0, 0, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].want);
            idle_for(pick_gap(1'b0));
        end

        for (int p = PLAN_ASCEND; p <= PLAN_DEFAULT; p++) begin
            drain_results();
            repeat (4) @(posedge i_clk);
            build_floor(edge_plan_t'(p));
            program_edges();
            calm = (p == PLAN_FLOOR) || (p == PLAN_SCATTER);
            done = 0;
            while (done < PHASE_ITEMS) begin
                it = random_item();
                send_item(it, PREDICTED, '0);
                if (it.func <= FUNC_CLEAR && !(it.func == FUNC_BURST && it.blen == 8'd0))
                    done++;
                idle_for(pick_gap(calm));
            end
        end

        drain_results();
        repeat (6) @(posedge i_clk);

        $display("Summary: %0d packet records, %0d burst records, %0d reads, %0d clears, %0d no-op items",
                 n_records, n_bursts, n_reads, n_clears, n_noops);
        $display("Summary: %0d results checked over %0d bin edge settings, %0d mismatches",
                 n_checked, n_settings, errors);
        if (errors == 0) begin
            $display("rssi_packet_outcome_histogram_core test passed");
        end else begin
            $display("rssi_packet_outcome_histogram_core test failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/rpoh_pkg.sv
rtl/rpoh_front.sv
rtl/rpoh_queue.sv
rtl/rpoh_back.sv
rtl/rssi_packet_outcome_histogram_core.sv
rtl/rpoh_checker.sv
tb/tb_top.sv
